// ===== rtl/core/pde_pkg.sv =====
// ---------------------------------------------------------------------------
// pde_pkg: shared types and helpers for the pixel depth expander
// Register indexes, the item record passed front to back, the expanded
// chunk record and a few bit helpers.
// ---------------------------------------------------------------------------
package pde_pkg;

   localparam int WORD_BITS = 32;

   // CSR register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_SRC_DEPTH_LOG    = 3'd0,
      REG_EXPAND_LOG       = 3'd1,
      REG_PIXEL_MULTIPLIER = 3'd2,
      REG_SRC_BIT_OFFSET   = 3'd3,
      REG_DEST_BIT_OFFSET  = 3'd4,
      REG_RUN_BITS         = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [1:0]  src_depth_log;
      logic [2:0]  expand_log;
      logic [31:0] pixel_multiplier;
      logic [4:0]  src_bit_offset;
      logic [4:0]  dest_bit_offset;
      logic [15:0] run_bits;
   } cfg_type;

   // one classified source word, front to back
   typedef struct packed {
      logic [31:0] word;
      logic        first;      // opens a run
      logic [4:0]  src_off;    // sampled at run start
      logic [4:0]  dest_off;
      logic [15:0] run_bits;
   } q_item_type;

   // up to 32 expanded bits, expand to pack
   typedef struct packed {
      logic [31:0] bits;
      logic [5:0]  nbits;      // 1..32
      logic        first;      // first chunk of a run
      logic [4:0]  dest_off;
      logic        end_run;    // last chunk of a run
   } chunk_type;

   function automatic logic [31:0] low_ones(input logic [5:0] n);
      low_ones = (n >= 6'd32) ? 32'hffff_ffff : ((32'd1 << n) - 32'd1);
   endfunction

   // true when at least one more pixel can be taken from the held bits
   function automatic logic can_take(input logic [5:0]  fill,
                                     input logic [15:0] remain,
                                     input logic [1:0]  sdl);
      logic [3:0] sbpp;
      logic [3:0] n;
      sbpp = 4'd1 << sdl;
      n = (remain < 16'(sbpp)) ? remain[3:0] : sbpp;
      can_take = (remain != 16'd0) && (fill >= 6'(n));
   endfunction

endpackage

// ===== rtl/core/pixel_depth_expander_core.sv =====
// ---------------------------------------------------------------------------
// pixel_depth_expander_core: packed pixel depth expander, top level
// CSR block plus front / queue / expand / pack pipeline.
// ---------------------------------------------------------------------------
// Takes 32-bit words of packed source pixels (1, 2, 4 or 8 bpp, LSB first)
// and writes each pixel widened by 2^expand_log (capped at 32 bits) and
// multiplied by pixel_multiplier into 32-bit dest words, from
// dest_bit_offset on, with a write mask per word and last on the final
// word of a run. A run opens on the first item after reset or after the
// previous run closed; src_bit_offset, dest_bit_offset and run_bits are
// sampled then, the other registers are used as they stand. The expand
// stage takes an item only once no further pixel can be drawn from the
// bits it holds; each step after a load widens up to a whole dest word
// of pixels in a lane array, and the run's final partial word may need a
// separate flush step in the pack stage. The default setup is 4 bpp with
// no widening. A dest word passes the front queue, the expand load,
// the chunk register and the output register. Program the registers
// only while the block is idle.
// ---------------------------------------------------------------------------
module pixel_depth_expander_core #(
   parameter int QUEUE_DEPTH = 2      // front to back item queue, >= 2
) (
   input  logic        clock,
   input  logic        reset,

   // source words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_src_word,

   // dest words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dest_word,
   output logic [31:0] rsp_write_mask,
   output logic        rsp_last,

   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pde_pkg::*;

   // --- CSRs -------------------------------------------------------------
   logic [1:0]  src_depth_log_ff;
   logic [2:0]  expand_log_ff;
   logic [31:0] pixel_multiplier_ff;
   logic [4:0]  src_bit_offset_ff;
   logic [4:0]  dest_bit_offset_ff;
   logic [15:0] run_bits_ff;
   logic        csr_write;
   logic [2:0]  csr_index;
   cfg_type     cfg;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         src_depth_log_ff    <= 2'd2;
         expand_log_ff       <= 3'd0;
         pixel_multiplier_ff <= 32'd1;
         src_bit_offset_ff   <= 5'd0;
         dest_bit_offset_ff  <= 5'd0;
         run_bits_ff         <= 16'd32;
      end else if (csr_write) begin
         case (csr_index)
            REG_SRC_DEPTH_LOG:    src_depth_log_ff    <= pwdata[1:0];
            REG_EXPAND_LOG:       expand_log_ff       <= pwdata[2:0];
            REG_PIXEL_MULTIPLIER: pixel_multiplier_ff <= pwdata;
            REG_SRC_BIT_OFFSET:   src_bit_offset_ff   <= pwdata[4:0];
            REG_DEST_BIT_OFFSET:  dest_bit_offset_ff  <= pwdata[4:0];
            REG_RUN_BITS:         run_bits_ff         <= pwdata[15:0];
            default: ;            // unmapped: write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SRC_DEPTH_LOG:    prdata = 32'(src_depth_log_ff);
         REG_EXPAND_LOG:       prdata = 32'(expand_log_ff);
         REG_PIXEL_MULTIPLIER: prdata = pixel_multiplier_ff;
         REG_SRC_BIT_OFFSET:   prdata = 32'(src_bit_offset_ff);
         REG_DEST_BIT_OFFSET:  prdata = 32'(dest_bit_offset_ff);
         REG_RUN_BITS:         prdata = 32'(run_bits_ff);
         default:              prdata = '0;
      endcase
   end

   assign cfg = '{src_depth_log:    src_depth_log_ff,
                  expand_log:       expand_log_ff,
                  pixel_multiplier: pixel_multiplier_ff,
                  src_bit_offset:   src_bit_offset_ff,
                  dest_bit_offset:  dest_bit_offset_ff,
                  run_bits:         run_bits_ff};

   // --- pipeline ---------------------------------------------------------
   logic       push;
   q_item_type push_item;
   logic       q_full;
   logic       q_valid;
   q_item_type q_item;
   logic       q_pop;
   logic       ch_valid;
   chunk_type  ch;
   logic       ch_stall;

   // front: accept, mark run starts, drop empty runs
   pde_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_src_word (req_src_word),
      .req_stall    (req_stall),
      .q_full       (q_full),
      .push         (push),
      .push_item    (push_item)
   );

   pde_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (q_pop)
   );

   // back, part 1: realign source bits, widen a dest word a cycle if unstalled
   pde_expand u_expand (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .ch_valid (ch_valid),
      .ch       (ch),
      .ch_stall (ch_stall)
   );

   // back, part 2: pack into dest words, masks, last flag
   pde_pack u_pack (
      .clock          (clock),
      .reset          (reset),
      .ch_valid       (ch_valid),
      .ch             (ch),
      .ch_stall       (ch_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dest_word  (rsp_dest_word),
      .rsp_write_mask (rsp_write_mask),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/core/pde_queue.sv =====
// ---------------------------------------------------------------------------
// pde_queue: short item queue between front and back
// Register based FIFO; lets front and back stall independently.
// ---------------------------------------------------------------------------
module pde_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pde_pkg::q_item_type push_item,
   output logic                full,
   output logic                q_valid,
   output pde_pkg::q_item_type q_item,
   input  logic                pop
);
   import pde_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   q_item_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/pde_front.sv =====
// ---------------------------------------------------------------------------
// pde_front: input acceptance and run tracking
// Marks run starts, samples run settings, drops words of empty runs.
// ---------------------------------------------------------------------------
module pde_front (
   input  logic                clock,
   input  logic                reset,
   input  pde_pkg::cfg_type    cfg,
   input  logic                req_valid,
   input  logic [31:0]         req_src_word,
   output logic                req_stall,
   input  logic                q_full,
   output logic                push,
   output pde_pkg::q_item_type push_item
);
   import pde_pkg::*;

   logic        in_run_ff, in_run_in;
   logic [15:0] need_ff, need_in;     // source bits still owed by later words
   logic        accept;
   logic        first;
   logic [5:0]  avail;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign avail     = 6'd32 - {1'b0, cfg.src_bit_offset};

   always_comb begin
      in_run_in = in_run_ff;
      need_in   = need_ff;
      push      = 1'b0;
      first     = 1'b0;
      if (accept) begin
         if (in_run_ff) begin
            push = 1'b1;
            if (need_ff > 16'd32) begin
               need_in = need_ff - 16'd32;
            end else begin
               in_run_in = 1'b0;
            end
         end else if (cfg.run_bits != 16'd0) begin
            push  = 1'b1;
            first = 1'b1;
            if (cfg.run_bits > 16'(avail)) begin
               in_run_in = 1'b1;
               need_in   = cfg.run_bits - 16'(avail);
            end
         end
      end
   end

   assign push_item = '{word:     req_src_word,
                        first:    first,
                        src_off:  cfg.src_bit_offset,
                        dest_off: cfg.dest_bit_offset,
                        run_bits: cfg.run_bits};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
         need_ff   <= '0;
      end else begin
         in_run_ff <= in_run_in;
         need_ff   <= need_in;
      end
   end

endmodule

// ===== rtl/core/pde_expand.sv =====
// ---------------------------------------------------------------------------
// pde_expand: source unpack and pixel widening
// Holds unread source bits; each step widens up to one dest word of
// pixels in parallel lanes and registers the chunk.
// ---------------------------------------------------------------------------
module pde_expand (
   input  logic                clock,
   input  logic                reset,
   input  pde_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  pde_pkg::q_item_type q_item,
   output logic                q_pop,
   output logic                ch_valid,
   output pde_pkg::chunk_type  ch,
   input  logic                ch_stall
);
   import pde_pkg::*;

   localparam int LANES = WORD_BITS;

   logic        busy_ff, busy_in;
   logic [39:0] bits_ff, bits_in;
   logic [5:0]  fill_ff, fill_in;
   logic [15:0] remain_ff, remain_in;
   logic        first_ff, first_in;
   logic [4:0]  dest_off_ff, dest_off_in;
   logic        ch_valid_ff, ch_valid_in;
   chunk_type   ch_ff, ch_in;

   logic [1:0]  sdl;
   logic [3:0]  dsum;
   logic [2:0]  dlog;
   logic [3:0]  sbpp;
   logic [16:0] rem_pix;
   logic [5:0]  avail_full;
   logic        all_avail;
   logic [16:0] avail_pix;
   logic [5:0]  k;
   logic [5:0]  m;
   logic        take_all;
   logic [5:0]  cb;
   logic [31:0] win;
   logic [5:0]  nbits;
   logic [31:0] dmask;
   logic [5:0]  fill_nx;
   logic [15:0] remain_nx;
   logic [39:0] bits_nx;
   logic [39:0] ld_bits;
   logic [5:0]  ld_fill;
   logic [15:0] ld_remain;
   logic        adv;
   logic [31:0] lane_out [LANES];
   logic [31:0] chunk_bits;

   assign sdl  = cfg.src_depth_log;
   assign dsum = {2'b00, sdl} + {1'b0, cfg.expand_log};
   assign dlog = (dsum > 4'd5) ? 3'd5 : dsum[2:0];
   assign sbpp = 4'd1 << sdl;

   // how many pixels this step: limited by held bits, run end and one word
   assign rem_pix    = (17'(remain_ff) + 17'(sbpp) - 17'd1) >> sdl;
   assign avail_full = fill_ff >> sdl;
   assign all_avail  = (remain_ff <= 16'(fill_ff));
   assign avail_pix  = all_avail ? rem_pix : 17'(avail_full);
   assign k          = 6'd32 >> dlog;
   assign m          = (avail_pix < 17'(k)) ? avail_pix[5:0] : k;
   assign take_all   = all_avail && (rem_pix <= 17'(k));
   assign cb         = take_all ? remain_ff[5:0] : (m << sdl);
   assign win        = bits_ff[31:0] & low_ones(cb);   // ragged tail pixel: high bits zero
   assign nbits      = m << dlog;
   assign dmask      = low_ones(6'd1 << dlog);

   assign fill_nx   = fill_ff - cb;
   assign remain_nx = remain_ff - 16'(cb);
   assign bits_nx   = bits_ff >> cb;

   assign ld_bits   = q_item.first ? 40'(q_item.word >> q_item.src_off)
                                   : (bits_ff | (40'(q_item.word) << fill_ff));
   assign ld_fill   = q_item.first ? (6'd32 - {1'b0, q_item.src_off})
                                   : (fill_ff + 6'd32);
   assign ld_remain = q_item.first ? q_item.run_bits : remain_ff;

   // one lane per pixel slot of a dest word
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int LW = (i < 1) ? 32 : (i < 2) ? 16 : (i < 4) ? 8 :
                          (i < 8) ? 4 : (i < 16) ? 2 : 1;
      localparam int PW = (LW < 8) ? LW : 8;

      logic [PW-1:0] cand  [4];
      logic [PW-1:0] pix;
      logic [LW-1:0] prod;
      logic [LW-1:0] prodm;
      logic [31:0]   place [6];

      for (genvar s = 0; s < 4; s++) begin : g_src
         if ((((i + 1) << s) <= WORD_BITS) && ((1 << s) <= PW)) begin : g_ok
            assign cand[s] = PW'(win[(i << s) +: (1 << s)]);
         end else begin : g_no
            assign cand[s] = '0;
         end
      end

      assign pix   = cand[sdl];
      assign prod  = LW'(pix) * cfg.pixel_multiplier[LW-1:0];
      assign prodm = prod & LW'(dmask);

      for (genvar d = 0; d < 6; d++) begin : g_dst
         if ((((i + 1) << d) <= WORD_BITS) && ((1 << d) <= LW)) begin : g_ok
            assign place[d] = 32'(prodm[(1 << d) - 1:0]) << (i << d);
         end else begin : g_no
            assign place[d] = '0;
         end
      end

      assign lane_out[i] = place[dlog];
   end

   always_comb begin
      chunk_bits = '0;
      for (int j = 0; j < LANES; j++) begin
         chunk_bits = chunk_bits | lane_out[j];
      end
   end

   assign adv   = !ch_valid_ff || !ch_stall;
   assign q_pop = adv && !busy_ff && q_valid;

   always_comb begin
      busy_in     = busy_ff;
      bits_in     = bits_ff;
      fill_in     = fill_ff;
      remain_in   = remain_ff;
      first_in    = first_ff;
      dest_off_in = dest_off_ff;
      ch_valid_in = ch_valid_ff;
      ch_in       = ch_ff;
      if (adv) begin
         ch_valid_in = 1'b0;
         if (busy_ff) begin
            ch_valid_in = 1'b1;
            ch_in = '{bits:     chunk_bits,
                      nbits:    nbits,
                      first:    first_ff,
                      dest_off: dest_off_ff,
                      end_run:  (remain_nx == 16'd0)};
            first_in = 1'b0;
            if (remain_nx == 16'd0) begin
               // run over: leftover source bits are dropped
               bits_in   = '0;
               fill_in   = '0;
               remain_in = '0;
               busy_in   = 1'b0;
            end else begin
               bits_in   = bits_nx;
               fill_in   = fill_nx;
               remain_in = remain_nx;
               busy_in   = can_take(fill_nx, remain_nx, sdl);
            end
         end else if (q_valid) begin
            bits_in   = ld_bits;
            fill_in   = ld_fill;
            remain_in = ld_remain;
            busy_in   = can_take(ld_fill, ld_remain, sdl);
            if (q_item.first) begin
               first_in    = 1'b1;
               dest_off_in = q_item.dest_off;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         bits_ff     <= '0;
         fill_ff     <= '0;
         remain_ff   <= '0;
         first_ff    <= 1'b0;
         dest_off_ff <= '0;
         ch_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         bits_ff     <= bits_in;
         fill_ff     <= fill_in;
         remain_ff   <= remain_in;
         first_ff    <= first_in;
         dest_off_ff <= dest_off_in;
         ch_valid_ff <= ch_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
   end

   assign ch_valid = ch_valid_ff;
   assign ch       = ch_ff;

endmodule

// ===== rtl/core/pde_pack.sv =====
// ---------------------------------------------------------------------------
// pde_pack: dest word packing and output register
// Appends chunks at the dest fill point, emits words with write masks
// and flags the final word of each run.
// ---------------------------------------------------------------------------
module pde_pack (
   input  logic               clock,
   input  logic               reset,
   input  logic               ch_valid,
   input  pde_pkg::chunk_type ch,
   output logic               ch_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_dest_word,
   output logic [31:0]        rsp_write_mask,
   output logic               rsp_last
);
   import pde_pkg::*;

   logic [31:0] ob_ff, ob_in;
   logic [4:0]  of_ff, of_in;
   logic [4:0]  head_ff, head_in;
   logic        flush_ff, flush_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic [31:0] out_mask_ff, out_mask_in;
   logic        out_last_ff, out_last_in;

   logic [31:0] base_bits;
   logic [4:0]  base_fill;
   logic [4:0]  base_head;
   logic [63:0] acc;
   logic [5:0]  fill_sum;
   logic        can_load;
   logic        take;
   logic [31:0] mask;

   assign base_bits = ch.first ? '0 : ob_ff;
   assign base_fill = ch.first ? ch.dest_off : of_ff;
   assign base_head = ch.first ? ch.dest_off : head_ff;
   assign acc       = {32'd0, base_bits} | ({32'd0, ch.bits} << base_fill);
   assign fill_sum  = {1'b0, base_fill} + ch.nbits;

   assign can_load = !out_valid_ff || !rsp_stall;
   assign take     = ch_valid && can_load && !flush_ff;
   assign ch_stall = !can_load || flush_ff;

   always_comb begin
      ob_in        = ob_ff;
      of_in        = of_ff;
      head_in      = head_ff;
      flush_in     = flush_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_mask_in  = out_mask_ff;
      out_last_in  = out_last_ff;
      mask         = '0;
      if (can_load) begin
         out_valid_in = 1'b0;
      end
      if (flush_ff && can_load) begin
         // tail word left after a full word in the run's last chunk
         mask         = low_ones({1'b0, of_ff}) & ~low_ones({1'b0, head_ff});
         out_valid_in = 1'b1;
         out_word_in  = ob_ff & mask;
         out_mask_in  = mask;
         out_last_in  = 1'b1;
         ob_in        = '0;
         of_in        = '0;
         head_in      = '0;
         flush_in     = 1'b0;
      end else if (take) begin
         if (fill_sum[5]) begin
            mask         = ~low_ones({1'b0, base_head});
            out_valid_in = 1'b1;
            out_word_in  = acc[31:0] & mask;
            out_mask_in  = mask;
            out_last_in  = ch.end_run && (fill_sum == 6'd32);
            ob_in        = acc[63:32];
            of_in        = fill_sum[4:0];
            head_in      = '0;
            flush_in     = ch.end_run && (fill_sum != 6'd32);
         end else if (ch.end_run) begin
            mask         = low_ones(fill_sum) & ~low_ones({1'b0, base_head});
            out_valid_in = 1'b1;
            out_word_in  = acc[31:0] & mask;
            out_mask_in  = mask;
            out_last_in  = 1'b1;
            ob_in        = '0;
            of_in        = '0;
            head_in      = '0;
         end else begin
            ob_in   = acc[31:0];
            of_in   = fill_sum[4:0];
            head_in = base_head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_ff        <= '0;
         of_ff        <= '0;
         head_ff      <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ob_ff        <= ob_in;
         of_ff        <= of_in;
         head_ff      <= head_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
      out_mask_ff <= out_mask_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_dest_word  = out_word_ff;
   assign rsp_write_mask = out_mask_ff;
   assign rsp_last       = out_last_ff;

endmodule
